### rtl/rgba_pixel_blend_macros.svh
// Assertion macros shared by the blend checker.
`ifndef RGBA_PIXEL_BLEND_MACROS_SVH
`define RGBA_PIXEL_BLEND_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define RPB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that is checked through reset as well.
`define RPB_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rpb_pkg.sv
// Shared constants and types of the RGBA pixel blend pipeline.
package rpb_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int NUM_W      = 24;
  localparam int DEN_W      = 16;
  localparam int Q_W        = 8;
  localparam int REM_W      = NUM_W + 1;
  localparam int DSR_W      = DEN_W + 1;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = Q_W / DIV_STAGES;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  localparam logic [2:0] MODE_ALPHA    = 3'd0;
  localparam logic [2:0] MODE_CLEAR    = 3'd1;
  localparam logic [2:0] MODE_SRC      = 3'd2;
  localparam logic [2:0] MODE_DST      = 3'd3;
  localparam logic [2:0] MODE_SRC_OVER = 3'd4;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic                    blend;
    logic                    a_zero;
    logic [NUM_CH-1:0][CH_W-1:0] byp;
  } side_t;

endpackage

### rtl/rpb_div_lane.sv
// Pipelined restoring divider lane giving round-half-up of num / den.
module rpb_div_lane import rpb_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);

  logic [REM_W-1:0] rem_r [0:DIV_STAGES];
  logic [DSR_W-1:0] dsr_r [0:DIV_STAGES];
  logic [Q_W-1:0]   q_r   [0:DIV_STAGES];

  // Rounding is folded into the operands: floor((2*num + den) / (2*den)).
  always_ff @(posedge clk) begin
    rem_r[0] <= {num, 1'b0} + REM_W'(den);
    dsr_r[0] <= {den, 1'b0};
    q_r[0]   <= '0;
  end

  // The quotient never exceeds 255 because num <= 255 * den, so eight
  // quotient bits cover every result.
  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    logic [REM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   q_nxt;

    always_comb begin
      logic [REM_W-1:0] shd;
      int               j;
      rem_nxt = rem_r[st];
      q_nxt   = q_r[st];
      for (int k = 0; k < DIV_STEPS; k++) begin
        j   = Q_W - 1 - st * DIV_STEPS - k;
        shd = REM_W'(dsr_r[st]) << j;
        if (rem_nxt >= shd) begin
          rem_nxt = rem_nxt - shd;
          q_nxt   = q_nxt | (Q_W'(1) << j);
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[st+1] <= rem_nxt;
      dsr_r[st+1] <= dsr_r[st];
      q_r[st+1]   <= q_nxt;
    end
  end

  assign quot = q_r[DIV_STAGES];

endmodule

### rtl/rgba_pixel_blend.sv
// Throughput: one request per clock; busy is low whenever reset is released.
// Nine register stages: input, weights, sums, a five-stage divider per colour
// (operand setup, then two quotient bits a stage) and the output register.
// Reset (synchronous, active low) clears the mode to alpha over and empties
// the pipeline; the receiver cannot stall, so results are never held back.
module rgba_pixel_blend import rpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_src_red,
  input  logic [7:0] in_src_green,
  input  logic [7:0] in_src_blue,
  input  logic [7:0] in_src_alpha,
  input  logic [7:0] in_dst_red,
  input  logic [7:0] in_dst_green,
  input  logic [7:0] in_dst_blue,
  input  logic [7:0] in_dst_alpha,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  input  logic       cfg_we,
  input  logic [2:0] cfg_blend_mode
);

  // The pipeline never stalls, so the only time a request is refused is
  // while reset is held.
  assign busy = ~rst_n;

  logic [2:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ALPHA;
    end else if (cfg_we) begin
      mode_r <= cfg_blend_mode;
    end
  end

  // Stage 1: register the request.
  logic  vld1_r;
  chan_t src1_r [0:NUM_CH-1];
  chan_t dst1_r [0:NUM_CH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      src1_r[0] <= in_src_red;
      src1_r[1] <= in_src_green;
      src1_r[2] <= in_src_blue;
      src1_r[3] <= in_src_alpha;
      dst1_r[0] <= in_dst_red;
      dst1_r[1] <= in_dst_green;
      dst1_r[2] <= in_dst_blue;
      dst1_r[3] <= in_dst_alpha;
    end
  end

  // Stage 2: source and destination weights, plus the mode decision.
  // The copy modes resolve here and their pixel rides along as a bypass.
  logic             vld2_r;
  logic [DEN_W-1:0] sw_r;
  logic [DEN_W-1:0] dw_r;
  chan_t            src2_r [0:2];
  chan_t            dst2_r [0:2];
  side_t            side2_r;
  side_t            side2_nxt;
  chan_t            inv_sa;

  always_comb begin
    side2_nxt        = '0;
    inv_sa           = 8'hFF - src1_r[3];
    case (mode_r)
      MODE_ALPHA, MODE_SRC_OVER: begin
        side2_nxt.blend = 1'b1;
      end
      MODE_CLEAR: begin
        side2_nxt.byp = '0;
      end
      MODE_SRC: begin
        for (int c = 0; c < NUM_CH; c++) begin
          side2_nxt.byp[c] = src1_r[c];
        end
      end
      default: begin
        // Keep destination, and the unused codes behave the same way.
        for (int c = 0; c < NUM_CH; c++) begin
          side2_nxt.byp[c] = dst1_r[c];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    sw_r    <= DEN_W'(src1_r[3]) * DEN_W'(255);
    dw_r    <= DEN_W'(dst1_r[3]) * DEN_W'(inv_sa);
    side2_r <= side2_nxt;
    for (int c = 0; c < 3; c++) begin
      src2_r[c] <= src1_r[c];
      dst2_r[c] <= dst1_r[c];
    end
  end

  // Stage 3: weighted colour sums and the combined alpha A. A is at most
  // 255 * 255, so sixteen bits hold it.
  logic             vld3_r;
  logic [NUM_W-1:0] num3_r [0:2];
  logic [DEN_W-1:0] a3_r;
  logic [DEN_W-1:0] a_nxt;
  side_t            side3_r;

  assign a_nxt = sw_r + dw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      num3_r[c] <= NUM_W'(src2_r[c]) * NUM_W'(sw_r) + NUM_W'(dst2_r[c]) * NUM_W'(dw_r);
    end
    a3_r    <= a_nxt;
    side3_r <= {side2_r.blend, (a_nxt == '0), side2_r.byp};
  end

  // Divider lanes: the three colours divide by A.
  chan_t quot [0:NUM_CH-1];

  for (genvar c = 0; c < 3; c++) begin : g_col
    rpb_div_lane u_div (
      .clk  (clk),
      .num  (num3_r[c]),
      .den  (a3_r),
      .quot (quot[c])
    );
  end

  // Alpha is round(A / 255) with A at most 255 * 255. Adding 127 turns the
  // rounding into a floor, and below 65535 the floor of t / 255 equals
  // (t + 1 + (t >> 8)) >> 8. The result waits in a delay line as long as
  // the colour lanes take.
  logic [DEN_W-1:0] a_rnd;
  logic [DEN_W-1:0] a_fold;
  chan_t            alpha_dly_r [0:DIV_LAT-1];

  assign a_rnd  = a3_r + DEN_W'(127);
  assign a_fold = a_rnd + DEN_W'(1) + DEN_W'(a_rnd[DEN_W-1:8]);

  always_ff @(posedge clk) begin
    alpha_dly_r[0] <= a_fold[DEN_W-1:8];
    for (int i = 1; i < DIV_LAT; i++) begin
      alpha_dly_r[i] <= alpha_dly_r[i-1];
    end
  end

  assign quot[3] = alpha_dly_r[DIV_LAT-1];

  // Valid bits and sideband travel beside the divider stages.
  logic  vld_dly_r  [0:DIV_LAT-1];
  side_t side_dly_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_dly_r[i] <= 1'b0;
      end
    end else begin
      vld_dly_r[0] <= vld3_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_dly_r[i] <= vld_dly_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_dly_r[0] <= side3_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  // Output stage: pick the blended pixel, the zero pixel when both alphas
  // are zero, or the bypass pixel of the copy modes.
  side_t side_out;
  chan_t pix_nxt [0:NUM_CH-1];
  chan_t pix_r   [0:NUM_CH-1];
  logic  out_vld_r;

  assign side_out = side_dly_r[DIV_LAT-1];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (!side_out.blend) begin
        pix_nxt[c] = side_out.byp[c];
      end else if (side_out.a_zero) begin
        pix_nxt[c] = '0;
      end else begin
        pix_nxt[c] = quot[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_dly_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      pix_r[c] <= pix_nxt[c];
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = pix_r[0];
  assign out_green = pix_r[1];
  assign out_blue  = pix_r[2];
  assign out_alpha = pix_r[3];

endmodule

### rtl/rpb_checker.sv
// Port-level checker for the RGBA pixel blend block and its bind.
`include "rgba_pixel_blend_macros.svh"

module rpb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_src_red,
  input logic [7:0] in_src_alpha,
  input logic [7:0] in_dst_red,
  input logic       out_valid,
  input logic [7:0] out_red
);

  logic req_acc;
  logic red_same;

  assign req_acc  = start && !busy;
  assign red_same = req_acc && (in_src_red == in_dst_red) && (in_src_alpha != 8'd0);

  // Equal red and a visible source give back that red, or zero when cleared.
  property p_red_fixpoint;
    (out_valid && $past(red_same, 9)) |->
      (out_red == $past(in_src_red, 9) || out_red == 8'd0);
  endproperty

  // Reset empties the pipeline, so no result follows a reset edge.
  `RPB_ASSERT_ALWAYS(a_reset_flush, clk, !rst_n |=> !out_valid, "result after reset")

  // Every request gives exactly one result.
  `RPB_ASSERT(a_req_to_res, clk, rst_n, req_acc |-> ##9 out_valid, "request lost")
  `RPB_ASSERT(a_res_from_req, clk, rst_n, out_valid |-> $past(req_acc, 9), "result invented")

  `RPB_ASSERT(a_red_fixpoint, clk, rst_n, p_red_fixpoint, "red blend wrong")

endmodule

bind rgba_pixel_blend rpb_checker u_rpb_checker (.*);

### tb/rgba_pixel_blend_tb.sv
// Self-checking testbench for the RGBA pixel blend block under all blend modes.
module rgba_pixel_blend_tb import rpb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes 5 to 7 are unused by the block. It treats them as keep destination.
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int PIPE_DEPTH = 9;
  // This many clocks in a row with no request and no result end the run. Even
  // the slowest correct run never comes near it.
  localparam int STALL_LIMIT = 1000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pixel_t;

  // One row of the directed table. Pixels are written as 32'hRRGGBBAA. When
  // "fixed" is set, the wanted pixel is typed in. Otherwise it is computed.
  typedef struct packed {
    logic [2:0] mode;
    logic       fixed;
    pixel_t     src;
    pixel_t     dst;
    pixel_t     want;
  } vector_t;

  // One phase of the random part: the mode, the share of clocks the sender
  // stays idle, and the number of requests.
  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  idle_pct;
    logic [10:0] count;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_blend_mode = MODE_ALPHA;
  pixel_t     src_px = '0;
  pixel_t     dst_px = '0;
  logic       out_valid;
  chan_t      out_red;
  chan_t      out_green;
  chan_t      out_blue;
  chan_t      out_alpha;

  // This copy of the mode register follows every write. The prediction of a
  // request uses the mode that holds when the block accepts it.
  logic [2:0] shadow_mode = MODE_ALPHA;
  pixel_t     pending_pixels[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;

  // The directed table covers the extremes of the fields, every mode, the
  // case where both alphas are zero, and the unused mode codes.
  vector_t directed_rows [0:19] = '{
    {MODE_ALPHA,    1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
    {MODE_ALPHA,    1'b1, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF},
    {MODE_ALPHA,    1'b1, 32'hA5C37E00, 32'h123456FF, 32'h123456FF},
    {MODE_ALPHA,    1'b0, 32'h8040C080, 32'h10F020FF, 32'h00000000},
    {MODE_ALPHA,    1'b1, 32'h11223301, 32'h00000000, 32'h11223301},
    {MODE_ALPHA,    1'b0, 32'hFF00FF80, 32'h00FF0080, 32'h00000000},
    {MODE_ALPHA,    1'b0, 32'h7F7F7F7F, 32'h808080FE, 32'h00000000},
    {MODE_ALPHA,    1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    {MODE_ALPHA,    1'b0, 32'h01FE01FE, 32'hFE01FE01, 32'h00000000},
    {MODE_SRC_OVER, 1'b1, 32'h5A5AA500, 32'hC3C3C300, 32'h00000000},
    {MODE_SRC_OVER, 1'b0, 32'h20406080, 32'hA0C0E040, 32'h00000000},
    {MODE_SRC_OVER, 1'b1, 32'h0A0B0CFF, 32'hF0F1F2F3, 32'h0A0B0CFF},
    {MODE_CLEAR,    1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000},
    {MODE_CLEAR,    1'b1, 32'h12345678, 32'h9ABCDEF0, 32'h00000000},
    {MODE_SRC,      1'b1, 32'hA55AFF00, 32'h5AA500FF, 32'hA55AFF00},
    {MODE_DST,      1'b1, 32'hA55AFF00, 32'h5AA500FF, 32'h5AA500FF},
    {MODE_SPARE5,   1'b1, 32'hFFFFFFFF, 32'h00000000, 32'h00000000},
    {MODE_SPARE6,   1'b1, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF},
    {MODE_SPARE7,   1'b1, 32'h13579BDF, 32'h2468ACE0, 32'h2468ACE0},
    {MODE_ALPHA,    1'b0, 32'h00FF0081, 32'hFF00FF7F, 32'h00000000}
  };

  // Most random requests use the two blending modes, because only they do
  // any arithmetic. The phases alternate between no idling, idling in about
  // half of the clocks, and idling in under a third of them.
  phase_t phase_plan [0:8] = '{
    {MODE_ALPHA,    7'd0,  11'd250},
    {MODE_SRC_OVER, 7'd49, 11'd250},
    {MODE_CLEAR,    7'd29, 11'd40},
    {MODE_SRC,      7'd0,  11'd40},
    {MODE_DST,      7'd49, 11'd40},
    {MODE_SPARE7,   7'd29, 11'd40},
    {MODE_ALPHA,    7'd49, 11'd250},
    {MODE_SRC_OVER, 7'd29, 11'd250},
    {MODE_ALPHA,    7'd0,  11'd250}
  };

  rgba_pixel_blend i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_src_red     (src_px.red),
    .in_src_green   (src_px.green),
    .in_src_blue    (src_px.blue),
    .in_src_alpha   (src_px.alpha),
    .in_dst_red     (dst_px.red),
    .in_dst_green   (dst_px.green),
    .in_dst_blue    (dst_px.blue),
    .in_dst_alpha   (dst_px.alpha),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .cfg_we         (cfg_we),
    .cfg_blend_mode (cfg_blend_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Divides with rounding half up and clamps the quotient to one byte.
  function automatic chan_t round_div_sat(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num * 2 + den) / (den * 2);
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  // Computes the new destination pixel. The source weight is SA*255 and the
  // destination weight is DA*(255-SA). Their sum is the coverage. The result
  // alpha is the coverage over 255. Each colour is the weighted sum over the
  // coverage.
  function automatic pixel_t blend_pixel(logic [2:0] mode, pixel_t s, pixel_t d);
    pixel_t          r;
    longint unsigned sw;
    longint unsigned dw;
    longint unsigned cov;
    sw  = longint'(s.alpha) * 255;
    dw  = longint'(d.alpha) * (255 - longint'(s.alpha));
    cov = sw + dw;
    case (mode)
      MODE_CLEAR: r = '0;
      MODE_SRC: r = s;
      MODE_ALPHA, MODE_SRC_OVER: begin
        // If both alphas are zero there is no coverage, and the result is all zeros.
        if (cov == 0) begin
          r = '0;
        end else begin
          r.red   = round_div_sat(s.red * sw + d.red * dw, cov);
          r.green = round_div_sat(s.green * sw + d.green * dw, cov);
          r.blue  = round_div_sat(s.blue * sw + d.blue * dw, cov);
          r.alpha = round_div_sat(cov, 255);
        end
      end
      default: r = d;
    endcase
    return r;
  endfunction

  // Extreme values and values next to them come up often, so that every bit
  // takes both values and the cases where an alpha is zero or full come up.
  function automatic chan_t random_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return $urandom_range(1) ? 8'h01 : 8'hFE;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_chan();
    p.green = random_chan();
    p.blue  = random_chan();
    p.alpha = random_chan();
    return p;
  endfunction

  // The mode is written only while the pipeline is empty. The shadow copy is
  // updated at the same time.
  task automatic set_blend_mode(logic [2:0] mode);
    @(negedge clk);
    cfg_we         <= 1'b1;
    cfg_blend_mode <= mode;
    @(negedge clk);
    cfg_we         <= 1'b0;
    shadow_mode     = mode;
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Sends one request after a random number of idle clocks. Inputs change
  // only at falling edges, and start gets one assignment per falling edge. It
  // stays high from one request to the next when there is no gap between them.
  task automatic push_request(pixel_t s, pixel_t d, int idle_pct, logic fixed, pixel_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    src_px <= s;
    dst_px <= d;
    do @(posedge clk); while (busy);
    pending_pixels.insert(pending_pixels.size(), fixed ? want : blend_pixel(shadow_mode, s, d));
  endtask

  task automatic note_mismatch(string what, chan_t want, chan_t got);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
    end
    mismatch_count++;
  endtask

  task automatic compare_chan(string what, chan_t want, chan_t got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  // Results cannot be held off, so each strobe is taken at the rising edge
  // that ends its cycle. It is checked against the oldest pending prediction.
  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected result, alpha", 8'h00, out_alpha);
      end else begin
        want = pending_pixels.pop_front();
        compare_chan("red", want.red, out_red);
        compare_chan("green", want.green, out_green);
        compare_chan("blue", want.blue, out_blue);
        compare_chan("alpha", want.alpha, out_alpha);
      end
    end
  end

  // The watchdog ends the run if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgba_pixel_blend test failed");
      $finish;
    end
  end

  initial begin : stimulus
    vector_t v;
    phase_t  p;
    // Synchronous reset is held from the start and released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The mode is rewritten whenever a row asks for a new one.
    // It is also written before the first row, even though that row uses the
    // reset value, so the write of the reset value is covered too.
    foreach (directed_rows[i]) begin
      v = directed_rows[i];
      if (i == 0 || v.mode != shadow_mode) begin
        drain();
        set_blend_mode(v.mode);
      end
      push_request(v.src, v.dst, 0, v.fixed, v.want);
    end

    // Random part. Each phase begins with an empty pipeline and a fresh write of its mode.
    foreach (phase_plan[k]) begin
      p = phase_plan[k];
      drain();
      set_blend_mode(p.mode);
      repeat (p.count) push_request(random_pixel(), random_pixel(), p.idle_pct, 1'b0, '0);
    end

    // Waits until nothing is pending. Then a few more clocks pass, so that a
    // stray result would still be caught.
    drain();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("rgba_pixel_blend test passed");
    end else begin
      $display("rgba_pixel_blend test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rpb_pkg.sv
rtl/rpb_div_lane.sv
rtl/rgba_pixel_blend.sv
rtl/rpb_checker.sv
tb/rgba_pixel_blend_tb.sv
